// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files.
// No dependencies; compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define KSDF_ASSERT_IMP(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("implication check failed");
`define KSDF_ASSERT_NXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("next-cycle check failed");
`else
`define KSDF_ASSERT_IMP(lbl, clk, rst, pre, post)
`define KSDF_ASSERT_NXT(lbl, clk, rst, pre, post)
`endif
`endif

// ===== rtl/ksdf_pkg.sv =====
// Types and constants of the keyed sequence-number duplicate filter.
// No dependencies.
package ksdf_pkg;
   localparam int ENTRIES   = 64;
   localparam int ENT_IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W     = $clog2(ENTRIES + 1);
   localparam int CSR_AW    = 3;

   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_TEST   = 2'd1;
   localparam logic [1:0] CMD_TICK   = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam logic [2:0] V_TOO_OLD   = 3'd0;
   localparam logic [2:0] V_DUPLICATE = 3'd1;
   localparam logic [2:0] V_CURRENT   = 3'd2;
   localparam logic [2:0] V_NEW       = 3'd3;
   localparam logic [2:0] V_NEWEST    = 3'd4;
   localparam logic [2:0] V_TICK      = 3'd5;

   localparam logic [7:0]  RUN_RESET   = 8'd32;
   localparam logic [15:0] OLD_LIMIT   = 16'hFFE1; // -31
   localparam logic        REG_MAX_RUN = 1'b0;

   typedef struct packed {
      logic [1:0]  command;
      logic [7:0]  msg_kind;
      logic [7:0]  addr_family;
      logic [63:0] addr_high;
      logic [63:0] addr_low;
      logic [7:0]  prefix_len;
      logic [15:0] seq_number;
      logic [30:0] valid_ticks;
   } req_type;

   typedef struct packed {
      logic [2:0] verdict;
      logic       table_full;
   } rsp_type;

   typedef struct packed {
      logic [63:0] key_high;
      logic [63:0] key_low;
      logic [23:0] key_tag;
      logic [15:0] newest;
      logic [31:0] window;
      logic [7:0]  run;
      logic [31:0] expiry;
   } ent_type;
endpackage

// ===== rtl/ksdf_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module ksdf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/keyed_seqno_duplicate_filter.sv =====
// Top level of the keyed sequence-number duplicate filter.
// Uses ksdf_pkg, ksdf_ram and assert_macros.svh.
//
//   channel | dir | handshake             | payload
//   req     | in  | req_valid / req_stall | req_data (ksdf_pkg::req_type)
//   rsp     | out | rsp_valid / rsp_stall | rsp_data (ksdf_pkg::rsp_type)
//   csr     | in  | csr_psel / csr_penable| csr_paddr, csr_pwdata, csr_prdata
//
// Add, test and tick each scan the entry table, one read a cycle from the
// entry RAM; the scan ends early when a test or add hits. An unused
// command skips the scan and goes straight to the update step.
// Reset clears the valid bits at once; there is no clearing pass.
// A held result stalls only the final update step; the next item is taken
// while the result waits in the output register.
`include "assert_macros.svh"
module keyed_seqno_duplicate_filter (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  ksdf_pkg::req_type            req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output ksdf_pkg::rsp_type            rsp_data,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [ksdf_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);
   import ksdf_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_UPDATE = 2'd2;

   logic [1:0]           state_ff, state_in;
   req_type              item_ff;
   logic [7:0]           max_run_ff;
   logic [31:0]          time_ff;
   logic [ENTRIES-1:0]   valid_ff, valid_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 pend_ff, pend_in;
   logic [ENT_IDX_W-1:0] pidx_ff, pidx_in;
   logic                 found_ff, found_in;
   logic [ENT_IDX_W-1:0] hit_ff, hit_in;
   logic                 free_ok_ff, free_ok_in;
   logic [ENT_IDX_W-1:0] free_ff, free_in;
   ent_type              rec_ff, rec_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 accept;
   logic                 tick_take;
   logic                 fire;
   logic                 rd_en;
   ent_type              rd_ent;
   logic [31:0]          left;
   logic                 live;
   logic                 match;
   logic                 wr_en;
   logic [ENT_IDX_W-1:0] wr_idx;
   ent_type              wr_ent;
   logic [2:0]           verdict;
   logic                 full;

   // classification terms
   logic [15:0] seq_gap;
   logic        too_old;
   logic [4:0]  back_pos;
   logic [31:0] back_bit;
   logic [7:0]  run_inc;
   logic        resync;
   logic        is_add;
   logic [31:0] expiry_new;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign tick_take = accept && (req_data.command == CMD_TICK);
   assign req_stall = (state_ff != ST_IDLE);
   assign fire      = (state_ff == ST_UPDATE) && (!rsp_valid_ff || !rsp_stall);

   // config register
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_MAX_RUN) ? {24'd0, max_run_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_run_ff <= RUN_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == REG_MAX_RUN) begin
         max_run_ff <= csr_pwdata[7:0];
      end
   end

   // entry store, one read per scan cycle
   assign rd_en = (state_ff == ST_SCAN) && (cnt_ff < CNT_W'(ENTRIES));

   ksdf_ram #(.WIDTH($bits(ent_type)), .DEPTH(ENTRIES)) u_ent_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_idx),
      .wr_data (wr_ent),
      .rd_en   (rd_en),
      .rd_addr (cnt_ff[ENT_IDX_W-1:0]),
      .rd_data (rd_ent)
   );

   // liveness and key compare of the entry just read
   assign left  = rd_ent.expiry - time_ff;
   assign live  = valid_ff[pidx_ff] && (left != 32'd0) && !left[31];
   assign match = live && (item_ff.command != CMD_TICK) &&
                  (rd_ent.key_tag == {item_ff.msg_kind, item_ff.addr_family,
                                      item_ff.prefix_len}) &&
                  (rd_ent.key_high == item_ff.addr_high) &&
                  (rd_ent.key_low == item_ff.addr_low);

   // scan control
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      pend_in    = 1'b0;
      pidx_in    = cnt_ff[ENT_IDX_W-1:0];
      found_in   = found_ff;
      hit_in     = hit_ff;
      free_ok_in = free_ok_ff;
      free_in    = free_ff;
      rec_in     = rec_ff;
      valid_in   = valid_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cnt_in     = '0;
               found_in   = 1'b0;
               free_ok_in = 1'b0;
               state_in   = (req_data.command == CMD_UNUSED) ? ST_UPDATE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_en) begin
               cnt_in  = cnt_ff + 1'b1;
               pend_in = 1'b1;
            end
            if (pend_ff) begin
               if (item_ff.command == CMD_TICK && !live) begin
                  valid_in[pidx_ff] = 1'b0;
               end
               if (match) begin
                  found_in = 1'b1;
                  hit_in   = pidx_ff;
                  rec_in   = rd_ent;
                  pend_in  = 1'b0;
                  state_in = ST_UPDATE;
               end else begin
                  if (!live && !free_ok_ff) begin
                     free_ok_in = 1'b1;
                     free_in    = pidx_ff;
                  end
                  if (pidx_ff == ENT_IDX_W'(ENTRIES - 1)) begin
                     state_in = ST_UPDATE;
                  end
               end
            end
         end
         ST_UPDATE: begin
            if (fire) begin
               state_in = ST_IDLE;
               if (wr_en && !found_ff) begin
                  valid_in[wr_idx] = 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // classification of the hit entry
   assign is_add     = (item_ff.command == CMD_ADD);
   assign seq_gap    = item_ff.seq_number - rec_ff.newest;
   assign too_old    = seq_gap[15] && (seq_gap < OLD_LIMIT);
   assign back_pos   = 5'(~seq_gap + 16'd1);
   assign back_bit   = 32'd1 << back_pos;
   assign run_inc    = (rec_ff.run == 8'hFF) ? rec_ff.run : rec_ff.run + 8'd1;
   assign resync     = run_inc > max_run_ff;
   assign expiry_new = time_ff + {1'b0, item_ff.valid_ticks};

   always_comb begin
      wr_ent  = rec_ff;
      wr_idx  = hit_ff;
      wr_en   = 1'b0;
      verdict = V_TICK;
      full    = 1'b0;
      if (item_ff.command == CMD_ADD || item_ff.command == CMD_TEST) begin
         if (found_ff) begin
            wr_en = fire;
            if (seq_gap == 16'd0) begin
               verdict = V_CURRENT;
            end else if (too_old) begin
               wr_ent.run = run_inc;
               if (resync) begin
                  wr_ent.window = 32'd1;
                  wr_ent.run    = 8'd0;
                  wr_ent.newest = item_ff.seq_number;
                  verdict       = V_NEWEST;
               end else begin
                  verdict = V_TOO_OLD;
               end
            end else if (seq_gap[15]) begin
               wr_ent.run = 8'd0;
               if ((rec_ff.window & back_bit) != 32'd0) begin
                  verdict = V_DUPLICATE;
               end else begin
                  if (is_add) begin
                     wr_ent.window = rec_ff.window | back_bit;
                  end
                  verdict = V_NEW;
               end
            end else begin
               wr_ent.run = 8'd0;
               if (is_add) begin
                  wr_ent.newest = item_ff.seq_number;
                  wr_ent.window = (seq_gap >= 16'd32) ? 32'd1 :
                                  ((rec_ff.window << seq_gap[4:0]) | 32'd1);
               end
               verdict = V_NEWEST;
            end
            if (is_add && (verdict == V_NEW || verdict == V_NEWEST)) begin
               wr_ent.expiry = expiry_new;
            end
         end else if (!is_add) begin
            verdict = V_NEWEST;
         end else if (free_ok_ff) begin
            // new key takes the lowest free slot
            wr_en          = fire;
            wr_idx         = free_ff;
            wr_ent.key_high = item_ff.addr_high;
            wr_ent.key_low  = item_ff.addr_low;
            wr_ent.key_tag  = {item_ff.msg_kind, item_ff.addr_family, item_ff.prefix_len};
            wr_ent.newest   = item_ff.seq_number;
            wr_ent.window   = 32'd1;
            wr_ent.run      = 8'd0;
            wr_ent.expiry   = expiry_new;
            verdict         = V_NEWEST;
         end else begin
            verdict = V_TOO_OLD;
            full    = 1'b1;
         end
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (fire) begin
         rsp_valid_in       = 1'b1;
         rsp_in.verdict     = verdict;
         rsp_in.table_full  = full;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         time_ff      <= 32'd0;
         pend_ff      <= 1'b0;
         found_ff     <= 1'b0;
         free_ok_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         pend_ff      <= pend_in;
         found_ff     <= found_in;
         free_ok_ff   <= free_ok_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         if (tick_take) begin
            time_ff <= time_ff + 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_data;
      end
      pidx_ff <= pidx_in;
      hit_ff  <= hit_in;
      free_ff <= free_in;
      rec_ff  <= rec_in;
      rsp_ff  <= rsp_in;
   end

   `KSDF_ASSERT_IMP(a_cnt_bound, clock, reset, state_ff == ST_SCAN, cnt_ff <= CNT_W'(ENTRIES))
   `KSDF_ASSERT_NXT(a_tick_time, clock, reset, tick_take, time_ff == $past(time_ff) + 32'd1)
   `KSDF_ASSERT_IMP(a_no_overwrite, clock, reset, rsp_valid_ff && rsp_stall, !fire)
   `KSDF_ASSERT_IMP(a_write_in_update, clock, reset, wr_en, state_ff == ST_UPDATE)
endmodule

// ===== test/keyed_seqno_duplicate_filter_test.sv =====
// Testbench for keyed_seqno_duplicate_filter: drives add, test, tick and unused-command transfers
// and checks every verdict and full flag against a behavioral copy of the entry table.
// Depends on ksdf_pkg and the RTL top level.
`timescale 1ns / 100ps
module keyed_seqno_duplicate_filter_test;
   import ksdf_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   keyed_seqno_duplicate_filter dut (.*);

   always #5 clock = ~clock;

   // predictor copy of the filter state
   logic [7:0]  max_run;
   logic        tbl_valid [ENTRIES];
   logic [63:0] tbl_high  [ENTRIES];
   logic [63:0] tbl_low   [ENTRIES];
   logic [23:0] tbl_tag   [ENTRIES];
   logic [15:0] tbl_seq   [ENTRIES];
   logic [31:0] tbl_win   [ENTRIES];
   logic [7:0]  tbl_run   [ENTRIES];
   logic [31:0] tbl_exp   [ENTRIES];
   logic [31:0] now_ticks;

   rsp_type verdict_queue [$];
   int  error_count = 0;
   int  idle_pct = 29;    // chance of a gap per cycle, both sides
   int  quiet_cycles = 0;

   // small key pool so adds and tests collide
   logic [63:0] pool_high [8];
   logic [63:0] pool_low  [8];

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   function automatic bit entry_live(input int i);
      logic [31:0] left;
      left = tbl_exp[i] - now_ticks;
      return tbl_valid[i] && left != 0 && !left[31];
   endfunction

   // classify against entry i, updating run counter and window as the block does
   function automatic logic [2:0] classify_seq(input int i, input logic [15:0] seq,
                                               input bit record);
      logic [15:0] d;
      int diff;
      d = seq - tbl_seq[i];
      if (seq == tbl_seq[i]) return V_CURRENT;
      diff = d[15] ? int'(d) - 65536 : int'(d);
      if (diff < -31) begin
         if (tbl_run[i] != 8'hFF) tbl_run[i]++;
         if (tbl_run[i] > max_run) begin
            tbl_win[i] = 32'd1; tbl_run[i] = 8'd0; tbl_seq[i] = seq;
            return V_NEWEST;
         end
         return V_TOO_OLD;
      end
      tbl_run[i] = 8'd0;
      if (diff <= 0) begin
         if (tbl_win[i][-diff]) return V_DUPLICATE;
         if (record) tbl_win[i][-diff] = 1'b1;
         return V_NEW;
      end
      if (record) begin
         tbl_seq[i] = seq;
         tbl_win[i] = (diff >= 32) ? 32'd1 : ((tbl_win[i] << diff) | 32'd1);
      end
      return V_NEWEST;
   endfunction

   function automatic rsp_type predict_verdict(input req_type r);
      rsp_type o;
      logic [23:0] tag;
      int hit;
      o.verdict = V_TICK; o.table_full = 1'b0;
      tag = {r.msg_kind, r.addr_family, r.prefix_len};
      hit = -1;
      if (r.command == CMD_TICK) begin
         now_ticks++;
         for (int i = 0; i < ENTRIES; i++) if (!entry_live(i)) tbl_valid[i] = 1'b0;
      end else if (r.command == CMD_ADD || r.command == CMD_TEST) begin
         for (int i = 0; i < ENTRIES && hit < 0; i++)
            if (entry_live(i) && tbl_tag[i] == tag && tbl_high[i] == r.addr_high
                && tbl_low[i] == r.addr_low) hit = i;
         if (hit >= 0) begin
            o.verdict = classify_seq(hit, r.seq_number, r.command == CMD_ADD);
            if (r.command == CMD_ADD && (o.verdict == V_NEW || o.verdict == V_NEWEST))
               tbl_exp[hit] = now_ticks + {1'b0, r.valid_ticks};
         end else if (r.command == CMD_TEST) begin
            o.verdict = V_NEWEST;
         end else begin
            for (int i = 0; i < ENTRIES && hit < 0; i++) if (!entry_live(i)) hit = i;
            if (hit >= 0) begin
               tbl_valid[hit] = 1'b1; tbl_high[hit] = r.addr_high;
               tbl_low[hit] = r.addr_low; tbl_tag[hit] = tag;
               tbl_seq[hit] = r.seq_number; tbl_win[hit] = 32'd1; tbl_run[hit] = 8'd0;
               tbl_exp[hit] = now_ticks + {1'b0, r.valid_ticks};
               o.verdict = V_NEWEST;
            end else begin
               o.verdict = V_TOO_OLD; o.table_full = 1'b1;
            end
         end
      end
      return o;
   endfunction

   // one transfer on the request channel; prediction made at acceptance
   // valid stays high after the transfer until the next call or a drain drops it
   task automatic send_item(input req_type r);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      verdict_queue.push_back(predict_verdict(r));
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (verdict_queue.size() != 0) @(negedge clock);
      repeat (2 * ENTRIES + 10) @(negedge clock);
   endtask

   task automatic write_max_run(input logic [7:0] v);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= CSR_AW'(4 * REG_MAX_RUN); csr_pwdata <= {24'd0, v};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      max_run = v;
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
   endtask

   function automatic req_type make_item(input logic [1:0] cmd, input int k,
                                         input logic [15:0] seq, input logic [30:0] vt);
      req_type r;
      r = '0;
      r.command = cmd; r.msg_kind = 8'(k); r.addr_family = 8'd1;
      r.addr_high = pool_high[k % 8]; r.addr_low = pool_low[k % 8];
      r.prefix_len = 8'd128; r.seq_number = seq; r.valid_ticks = vt;
      return r;
   endfunction

   // extremes, every verdict, absent key, expiry, unused command
   task automatic test_directed();
      req_type r;
      send_item(make_item(CMD_TEST, 0, 16'd100, 31'd50));   // absent on test
      send_item(make_item(CMD_ADD, 0, 16'd100, 31'd50));    // insert
      send_item(make_item(CMD_ADD, 0, 16'd100, 31'd50));    // current
      send_item(make_item(CMD_ADD, 0, 16'd98, 31'd50));     // new
      send_item(make_item(CMD_TEST, 0, 16'd98, 31'd50));    // duplicate
      send_item(make_item(CMD_ADD, 0, 16'd69, 31'd50));     // edge of window
      send_item(make_item(CMD_ADD, 0, 16'd68, 31'd50));     // too old
      send_item(make_item(CMD_ADD, 0, 16'd140, 31'd50));    // newest far jump
      send_item(make_item(CMD_ADD, 0, 16'hFFFF, 31'h7FFFFFFF)); // wrap, too old
      send_item(make_item(CMD_ADD, 1, 16'd5, 31'd0));       // expires at once
      send_item(make_item(CMD_TEST, 1, 16'd5, 31'd0));
      send_item(make_item(CMD_ADD, 2, 16'd7, 31'd2));
      send_item(make_item(CMD_TICK, 0, 16'd0, 31'd0));
      send_item(make_item(CMD_TICK, 0, 16'd0, 31'd0));      // key 2 drops out
      send_item(make_item(CMD_TEST, 2, 16'd7, 31'd0));
      r = '1; r.command = CMD_UNUSED;
      send_item(r);                                         // unused command
      r = '1; r.command = CMD_ADD;
      send_item(r);                                         // all-ones key
      r = '0;
      send_item(r);                                         // all-zero key
      drain_results();
   endtask

   // resync after a run of too-old numbers, at register extremes
   task automatic test_resync(input logic [7:0] lim);
      write_max_run(lim);
      send_item(make_item(CMD_ADD, 3, 16'd1000, 31'd100000));
      for (int i = 0; i < 4; i++) send_item(make_item(CMD_TEST, 3, 16'd10, 31'd1));
      send_item(make_item(CMD_ADD, 3, 16'd1001, 31'd100000));
      drain_results();
   endtask

   // fill the table to see the full flag
   task automatic test_table_full();
      req_type r;
      for (int i = 0; i < ENTRIES + 2; i++) begin
         r = make_item(CMD_ADD, 4, 16'(i), 31'd3);
         r.addr_low = 64'(i) ^ 64'hA5A5_0000_0000_0000;
         send_item(r);
      end
      for (int i = 0; i < 4; i++) send_item(make_item(CMD_TICK, 0, 16'd0, 31'd0));
      drain_results();
   endtask

   task automatic test_random(input int count);
      req_type r;
      logic [15:0] base;
      base = 16'($urandom);
      for (int n = 0; n < count; n++) begin
         if (n == count / 2) idle_pct = 0;          // burst with no gaps
         if (n == count / 2 + 60) idle_pct = 29;
         if (n == count / 4) drain_results();       // sender holds until empty
         r = make_item(($urandom_range(99) < 8) ? CMD_TICK :
                       2'($urandom_range(1)), $urandom_range(7),
                       base + 16'($urandom_range(80)) - 16'd40,
                       31'($urandom_range(60)));
         if ($urandom_range(99) < 5) r.seq_number = 16'($urandom);
         if ($urandom_range(99) < 5) r.valid_ticks = 31'($urandom);
         if ($urandom_range(99) < 4) begin
            r.addr_high = {$urandom, $urandom}; r.addr_low = {$urandom, $urandom};
            r.msg_kind = 8'($urandom); r.addr_family = 8'($urandom);
            r.prefix_len = 8'($urandom_range(128));
         end
         if ($urandom_range(99) < 2) r.command = CMD_UNUSED;
         if ($urandom_range(99) < 20) base = base + 16'($urandom_range(20));
         send_item(r);
      end
      drain_results();
   endtask

   // result channel: random stall and compare with oldest expectation
   always @(negedge clock) rsp_stall <= ($urandom_range(99) < idle_pct);

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (verdict_queue.size() == 0) begin
            report_mismatch("unexpected result verdict", rsp_data.verdict, -1);
         end else begin
            if (rsp_data.verdict !== verdict_queue[0].verdict)
               report_mismatch("verdict", rsp_data.verdict, verdict_queue[0].verdict);
            if (rsp_data.table_full !== verdict_queue[0].table_full)
               report_mismatch("table_full", rsp_data.table_full,
                               verdict_queue[0].table_full);
            void'(verdict_queue.pop_front());
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < ENTRIES; i++) tbl_valid[i] = 1'b0;
      now_ticks = 0;
      max_run = RUN_RESET;
      for (int i = 0; i < 8; i++) begin
         pool_high[i] = {$urandom, $urandom};
         pool_low[i]  = {$urandom, $urandom};
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_resync(8'd0);
      test_resync(8'd2);
      test_resync(8'd255);
      test_resync(8'd254);
      test_table_full();
      write_max_run(8'd3);
      test_random(200);
      write_max_run(RUN_RESET);
      test_random(200);
      if (verdict_queue.size() != 0)
         report_mismatch("results left over", verdict_queue.size(), 0);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
